// File: design/alld_pkg.sv
`default_nettype none
package alld_pkg;

  // Default width of the bit and latch-gap timer
  localparam int TIMER_BITS_DEFAULT = 20;

  // Field widths
  localparam int COLOR_BITS = 8;
  localparam int PIXEL_BITS = 3 * COLOR_BITS;
  localparam int CNT_BITS   = 12;
  localparam int GAP_BITS   = 20;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = GAP_BITS;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LATCH_GAP = 3'd4;

  // Register reset values
  localparam logic [CNT_BITS-1:0] ONE_HIGH_RESET  = 12'd90;
  localparam logic [CNT_BITS-1:0] ONE_LOW_RESET   = 12'd35;
  localparam logic [CNT_BITS-1:0] ZERO_HIGH_RESET = 12'd35;
  localparam logic [CNT_BITS-1:0] ZERO_LOW_RESET  = 12'd90;
  localparam logic [GAP_BITS-1:0] LATCH_GAP_RESET = 20'd1000;

  // Bits per pixel, as loaded into the bit counter
  localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

  // Command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Classified word between front and back
  typedef struct packed {
    logic                  is_load;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  last;
  } alld_word_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } alld_q_stat_t;

endpackage
`default_nettype wire

// File: design/alld_front.sv
`default_nettype none
module alld_front
  import alld_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  command,
  input  wire logic [COLOR_BITS-1:0] green,
  input  wire logic [COLOR_BITS-1:0] red,
  input  wire logic [COLOR_BITS-1:0] blue,
  input  wire logic                  last_pixel,
  input  wire alld_q_stat_t          q_stat,
  output logic                       push,
  output alld_word_t                 push_word
);

  // Take a word whenever the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify: loads carry the packed pixel, ticks carry nothing useful
  always_comb begin
    push_word.is_load = (command == CMD_LOAD);
    push_word.pixel   = {green, red, blue};
    push_word.last    = last_pixel;
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

// File: design/alld_queue.sv
`default_nettype none
module alld_queue
  import alld_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire alld_word_t   push_word,
  input  wire logic         pop,
  output alld_word_t        pop_word,
  output alld_q_stat_t      q_stat
);

  alld_word_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.valid = (count != 2'd0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && q_stat.valid;
  assign pop_word = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_word;
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

// File: design/alld_back.sv
`default_nettype none
module alld_back
  import alld_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
  input  wire alld_q_stat_t             q_stat,
  input  wire alld_word_t               pop_word,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          line_level,
  output logic                          accepted,
  output logic                          buffer_free,
  output logic                          busy_res,
  output logic                          frame_latched
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  localparam int CW = (TIMER_BITS > GAP_BITS) ? TIMER_BITS : GAP_BITS;
  localparam logic [CW-1:0] TMAX = CW'({TIMER_BITS{1'b1}});
  localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

  // Zero counts as one tick, oversize clamps to the timer range
  function automatic logic [TIMER_BITS-1:0] tload(input logic [GAP_BITS-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w == '0) w = CW'(1);
    if (w > TMAX) w = TMAX;
    return w[TIMER_BITS-1:0];
  endfunction

  // Configuration registers
  logic [CNT_BITS-1:0] one_high_ticks, one_low_ticks, zero_high_ticks, zero_low_ticks;
  logic [GAP_BITS-1:0] latch_gap_ticks;

  // Engine state
  logic [1:0]            phase, phase_next;
  logic [PIXEL_BITS-1:0] bit_shifter, bit_shifter_next;
  logic [4:0]            bits_remaining, bits_remaining_next;
  logic [TIMER_BITS-1:0] phase_timer, phase_timer_next;
  logic                  frame_ends_after, frame_ends_after_next;
  logic [PIXEL_BITS-1:0] held_pixel, held_pixel_next;
  logic                  held_last, held_last_next;
  logic                  held_valid, held_valid_next;

  logic                  r_level, r_acc, r_busy, r_latched;
  logic [PIXEL_BITS-1:0] shifted;
  logic [4:0]            bits_dec;

  // Step the engine whenever the output register can take a result
  assign pop = q_stat.valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high_ticks  <= ONE_HIGH_RESET;
      one_low_ticks   <= ONE_LOW_RESET;
      zero_high_ticks <= ZERO_HIGH_RESET;
      zero_low_ticks  <= ZERO_LOW_RESET;
      latch_gap_ticks <= LATCH_GAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ONE_HIGH:  one_high_ticks  <= cfg_data[CNT_BITS-1:0];
        REG_ONE_LOW:   one_low_ticks   <= cfg_data[CNT_BITS-1:0];
        REG_ZERO_HIGH: zero_high_ticks <= cfg_data[CNT_BITS-1:0];
        REG_ZERO_LOW:  zero_low_ticks  <= cfg_data[CNT_BITS-1:0];
        REG_LATCH_GAP: latch_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // One word of work: a load fills the buffer if it is empty, a tick advances the waveform
  always_comb begin
    phase_next            = phase;
    bit_shifter_next      = bit_shifter;
    bits_remaining_next   = bits_remaining;
    phase_timer_next      = phase_timer;
    frame_ends_after_next = frame_ends_after;
    held_pixel_next       = held_pixel;
    held_last_next        = held_last;
    held_valid_next       = held_valid;
    r_level   = 1'b0;
    r_acc     = 1'b0;
    r_busy    = 1'b0;
    r_latched = 1'b0;
    shifted   = '0;
    bits_dec  = '0;

    if (pop_word.is_load) begin
      if (!held_valid) begin
        held_pixel_next = pop_word.pixel;
        held_last_next  = pop_word.last;
        held_valid_next = 1'b1;
        r_acc           = 1'b1;
      end
      r_level = (phase == PH_HIGH);
      r_busy  = (phase != PH_IDLE);
    end else begin
      // Waiting pixel starts now, and this tick already drives high
      if (phase == PH_IDLE && held_valid) begin
        bit_shifter_next      = held_pixel;
        frame_ends_after_next = held_last;
        held_valid_next       = 1'b0;
        bits_remaining_next   = BITS_PER_PIXEL;
        phase_next            = PH_HIGH;
        phase_timer_next      = tload(held_pixel[PIXEL_BITS-1] ?
                                      {8'd0, one_high_ticks} : {8'd0, zero_high_ticks});
      end
      case (phase_next)
        PH_HIGH: begin
          r_level = 1'b1;
          r_busy  = 1'b1;
          if (phase_timer_next == TONE) begin
            phase_next       = PH_LOW;
            phase_timer_next = tload(bit_shifter_next[PIXEL_BITS-1] ?
                                     {8'd0, one_low_ticks} : {8'd0, zero_low_ticks});
          end else begin
            phase_timer_next = phase_timer_next - TONE;
          end
        end
        PH_LOW: begin
          r_busy   = 1'b1;
          shifted  = {bit_shifter[PIXEL_BITS-2:0], 1'b0};
          bits_dec = (bits_remaining != 5'd0) ? bits_remaining - 5'd1 : 5'd0;
          if (phase_timer == TONE) begin
            bit_shifter_next    = shifted;
            bits_remaining_next = bits_dec;
            if (bits_dec != 5'd0) begin
              phase_next       = PH_HIGH;
              phase_timer_next = tload(shifted[PIXEL_BITS-1] ?
                                       {8'd0, one_high_ticks} : {8'd0, zero_high_ticks});
            end else if (frame_ends_after) begin
              phase_next       = PH_LATCH;
              phase_timer_next = tload(latch_gap_ticks);
            end else if (held_valid) begin
              bit_shifter_next      = held_pixel;
              frame_ends_after_next = held_last;
              held_valid_next       = 1'b0;
              bits_remaining_next   = BITS_PER_PIXEL;
              phase_next            = PH_HIGH;
              phase_timer_next      = tload(held_pixel[PIXEL_BITS-1] ?
                                            {8'd0, one_high_ticks} : {8'd0, zero_high_ticks});
            end else begin
              phase_next       = PH_IDLE;
              phase_timer_next = '0;
            end
          end else begin
            phase_timer_next = phase_timer - TONE;
          end
        end
        PH_LATCH: begin
          r_busy = 1'b1;
          phase_timer_next = phase_timer - TONE;
          if (phase_timer == TONE) begin
            r_latched             = 1'b1;
            phase_next            = PH_IDLE;
            frame_ends_after_next = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Engine state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      bit_shifter      <= '0;
      bits_remaining   <= '0;
      phase_timer      <= '0;
      frame_ends_after <= 1'b0;
      held_last        <= 1'b0;
      held_valid       <= 1'b0;
    end else if (pop) begin
      phase            <= phase_next;
      bit_shifter      <= bit_shifter_next;
      bits_remaining   <= bits_remaining_next;
      phase_timer      <= phase_timer_next;
      frame_ends_after <= frame_ends_after_next;
      held_last        <= held_last_next;
      held_valid       <= held_valid_next;
    end
  end

  // Held pixel payload, no reset
  always_ff @(posedge clk) begin
    if (pop) held_pixel <= held_pixel_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      line_level    <= r_level;
      accepted      <= r_acc;
      buffer_free   <= !held_valid_next;
      busy_res      <= r_busy;
      frame_latched <= r_latched;
    end
  end

`ifndef NO_ASSERTIONS
  a_bits_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HIGH || phase == PH_LOW) |-> (bits_remaining != 5'd0))
    else $error("bit phase with no bits left");
  a_latch_marked: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LATCH) |-> frame_ends_after)
    else $error("latch gap without last pixel");
  a_timer_live: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_IDLE) |-> (phase_timer != '0))
    else $error("timer expired in active phase");
  a_latch_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_latched) |-> busy_res)
    else $error("latch pulse while not busy");
  a_acc_fills: assert property (@(posedge clk) disable iff (rst)
    (out_valid && accepted) |-> !buffer_free)
    else $error("accepted load left buffer free");
`endif

endmodule
`default_nettype wire

// File: design/addressable_led_line_driver_unit.sv
// Addressable LED line driver: single-wire serial encoder for LED strings.
// Input channel (in_valid/in_ready): one word per command. A load word
// (command = 1) offers a pixel (green, red, blue, last_pixel) to a one-entry
// holding buffer; a tick word (command = 0) stands for one period of the
// data line. Every word yields exactly one result word on the output
// channel (out_valid/out_ready): line level, accepted, buffer_free, busy_res
// and frame_latched.
// Each taken word is written into the queue; its result is then held in
// the output register. Throughput: one word per cycle while out_ready is
// high; a two-entry queue separates the input side from the engine.
// When the receiver stalls, the output register holds its result and the
// queue fills; in_ready drops once it is full, and no word is lost.
// The user writes timing registers via cfg_write/cfg_index/cfg_data only
// while idle, which the block does not enforce; other indexes are ignored.
// Reset (rst, synchronous): line idle low, buffer empty, queue empty,
// timing registers back at their defaults.
`default_nettype none
module addressable_led_line_driver_unit
  import alld_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     command,
  input  wire logic [COLOR_BITS-1:0]    green,
  input  wire logic [COLOR_BITS-1:0]    red,
  input  wire logic [COLOR_BITS-1:0]    blue,
  input  wire logic                     last_pixel,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          line_level,
  output logic                          accepted,
  output logic                          buffer_free,
  output logic                          busy_res,
  output logic                          frame_latched,
  input  wire logic                     cfg_write,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

  alld_q_stat_t q_stat;
  alld_word_t   push_word;
  alld_word_t   pop_word;
  logic         push;
  logic         pop;

  alld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .green      (green),
    .red        (red),
    .blue       (blue),
    .last_pixel (last_pixel),
    .q_stat     (q_stat),
    .push       (push),
    .push_word  (push_word)
  );

  alld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  alld_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_stat        (q_stat),
    .pop_word      (pop_word),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .line_level    (line_level),
    .accepted      (accepted),
    .buffer_free   (buffer_free),
    .busy_res      (busy_res),
    .frame_latched (frame_latched)
  );

endmodule
`default_nettype wire

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alld_pkg::*;

  localparam int TMR_BITS = TIMER_BITS_DEFAULT;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES = 8;
  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_OFF_AT = 650;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_MAX = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd5;

  // Line phases of the predictor
  typedef enum logic [1:0] {LINE_IDLE, LINE_HIGH, LINE_LOW, LINE_LATCH} line_phase_e;

  // One result word, in port order
  typedef struct packed {
    logic level;
    logic accepted;
    logic free;
    logic busy;
    logic latched;
  } line_res_t;

  // Directed stimulus rows
  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic                     cmd;
    logic [COLOR_BITS-1:0]    g;
    logic [COLOR_BITS-1:0]    r;
    logic [COLOR_BITS-1:0]    b;
    logic                     last;
    int                       reps;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] val;
    bit                       typed;
    line_res_t                want;
  } plan_row_t;

  // DUT ports
  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     command = CMD_TICK;
  logic [COLOR_BITS-1:0]    green = '0;
  logic [COLOR_BITS-1:0]    red = '0;
  logic [COLOR_BITS-1:0]    blue = '0;
  logic                     last_pixel = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     line_level;
  logic                     accepted;
  logic                     buffer_free;
  logic                     busy_res;
  logic                     frame_latched;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  addressable_led_line_driver_unit DUT (.*);

  // Timing registers as the predictor sees them
  logic [CNT_BITS-1:0] t_one_hi = ONE_HIGH_RESET;
  logic [CNT_BITS-1:0] t_one_lo = ONE_LOW_RESET;
  logic [CNT_BITS-1:0] t_zero_hi = ZERO_HIGH_RESET;
  logic [CNT_BITS-1:0] t_zero_lo = ZERO_LOW_RESET;
  logic [GAP_BITS-1:0] t_gap = LATCH_GAP_RESET;

  // Predictor state
  line_phase_e           line_ph = LINE_IDLE;
  logic [PIXEL_BITS-1:0] out_bits = '0;
  logic [4:0]            bits_to_go = '0;
  logic [TMR_BITS-1:0]   dwell = '0;
  logic                  end_of_frame = 1'b0;
  logic [PIXEL_BITS-1:0] hold_pix = '0;
  logic                  hold_last = 1'b0;
  logic                  hold_full = 1'b0;

  line_res_t line_status_q[$];
  plan_row_t plan[$];

  bit sender_steady = 1'b0;
  int burst_left = 0;
  int fault_cnt = 0;
  int n_checked = 0;
  int n_ticks = 0;
  int n_loads = 0;
  int n_refused = 0;
  int n_pixels = 0;
  int n_frames = 0;
  int n_settings = 1;
  int stuck_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Timer reload: zero counts as one tick, clamp to the timer range
  function automatic logic [TMR_BITS-1:0] dwell_load(input longint unsigned ticks);
    longint unsigned cap;
    cap = (64'd1 << TMR_BITS) - 1;
    if (ticks == 0) ticks = 1;
    if (ticks > cap) ticks = cap;
    return ticks[TMR_BITS-1:0];
  endfunction

  function automatic void launch_bit();
    line_ph = LINE_HIGH;
    dwell = dwell_load(out_bits[PIXEL_BITS-1] ? t_one_hi : t_zero_hi);
  endfunction

  function automatic void fetch_pixel();
    out_bits = hold_pix;
    end_of_frame = hold_last;
    hold_full = 1'b0;
    bits_to_go = BITS_PER_PIXEL;
    n_pixels++;
    launch_bit();
  endfunction

  // Predict the result word of one input word and advance the line
  function automatic line_res_t advance_line(input logic cmd, input logic [PIXEL_BITS-1:0] pix,
                                             input logic last);
    line_res_t res;
    res = '0;
    if (cmd == CMD_LOAD) begin
      n_loads++;
      if (!hold_full) begin
        hold_pix = pix;
        hold_last = last;
        hold_full = 1'b1;
        res.accepted = 1'b1;
      end else begin
        n_refused++;
      end
      res.level = (line_ph == LINE_HIGH);
      res.busy = (line_ph != LINE_IDLE);
    end else begin
      n_ticks++;
      if (line_ph == LINE_IDLE && hold_full) fetch_pixel();
      case (line_ph)
        LINE_HIGH: begin
          res.level = 1'b1;
          res.busy = 1'b1;
          dwell = dwell - 1'b1;
          if (dwell == 0) begin
            line_ph = LINE_LOW;
            dwell = dwell_load(out_bits[PIXEL_BITS-1] ? t_one_lo : t_zero_lo);
          end
        end
        LINE_LOW: begin
          res.busy = 1'b1;
          dwell = dwell - 1'b1;
          if (dwell == 0) begin
            out_bits = out_bits << 1;
            if (bits_to_go != 0) bits_to_go = bits_to_go - 1'b1;
            if (bits_to_go != 0) launch_bit();
            else if (end_of_frame) begin
              line_ph = LINE_LATCH;
              dwell = dwell_load(t_gap);
            end else if (hold_full) fetch_pixel();
            else line_ph = LINE_IDLE;
          end
        end
        LINE_LATCH: begin
          res.busy = 1'b1;
          dwell = dwell - 1'b1;
          if (dwell == 0) begin
            res.latched = 1'b1;
            line_ph = LINE_IDLE;
            end_of_frame = 1'b0;
            n_frames++;
          end
        end
        default: ;
      endcase
    end
    res.free = !hold_full;
    return res;
  endfunction

  // Offer one word, wait for the handshake, record what must come back
  task automatic send_item(input logic cmd, input logic [PIXEL_BITS-1:0] pix, input logic last,
                           input bit typed, input line_res_t want);
    line_res_t model_res;
    in_valid <= 1'b1;
    command <= cmd;
    green <= pix[23:16];
    red <= pix[15:8];
    blue <= pix[7:0];
    last_pixel <= last;
    do @(posedge clk); while (!in_ready);
    model_res = advance_line(cmd, pix, last);
    line_status_q.push_back(typed ? want : model_res);
    // bursts with random gaps in between
    if (!sender_steady) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Stop sending until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    drain_results();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_ONE_HIGH:  t_one_hi = val[CNT_BITS-1:0];
      REG_ONE_LOW:   t_one_lo = val[CNT_BITS-1:0];
      REG_ZERO_HIGH: t_zero_hi = val[CNT_BITS-1:0];
      REG_ZERO_LOW:  t_zero_lo = val[CNT_BITS-1:0];
      REG_LATCH_GAP: t_gap = val[GAP_BITS-1:0];
      default: ;
    endcase
  endtask

  // Tick until the line is idle and nothing is held
  task automatic flush_line();
    while (line_ph != LINE_IDLE || hold_full) send_item(CMD_TICK, '0, 1'b0, 1'b0, '0);
  endtask

  task automatic set_timing(input logic [CFG_DATA_BITS-1:0] one_hi, one_lo, zero_hi, zero_lo,
                            input logic [CFG_DATA_BITS-1:0] gap);
    flush_line();
    write_reg(REG_ONE_HIGH, one_hi);
    write_reg(REG_ONE_LOW, one_lo);
    write_reg(REG_ZERO_HIGH, zero_hi);
    write_reg(REG_ZERO_LOW, zero_lo);
    write_reg(REG_LATCH_GAP, gap);
    n_settings++;
  endtask

  // Random traffic: pixels loaded into a free buffer, ticks in between,
  // a few loads thrown at a full buffer
  task automatic run_random(input int quota, input bit pause_midway);
    int done_items;
    bit paused;
    logic is_load;
    logic [PIXEL_BITS-1:0] pix;
    logic last;
    done_items = 0;
    paused = 1'b0;
    while (done_items < quota) begin
      if (pause_midway && !paused && done_items >= quota / 2) begin
        drain_results();
        paused = 1'b1;
      end
      pix = PIXEL_BITS'($urandom());
      last = ($urandom_range(0, 3) == 0);
      if (hold_full) is_load = ($urandom_range(0, 19) == 0);
      else is_load = ($urandom_range(0, 99) < ((line_ph == LINE_IDLE) ? 40 : 4));
      if (!(is_load && hold_full)) done_items++;
      send_item(is_load ? CMD_LOAD : CMD_TICK, pix, last, 1'b0, '0);
    end
  endtask

  // Receiver: random ready pattern, one long hold-off, result checking
  initial begin : receiver
    line_res_t got;
    line_res_t want;
    int hold_left;
    int epoch_left;
    int mode;
    bit held_once;
    hold_left = 0;
    epoch_left = 0;
    mode = 0;
    held_once = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = {line_level, accepted, buffer_free, busy_res, frame_latched};
        n_checked++;
        if (line_status_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= REPORT_MAX)
            $display("result %0d arrived with nothing expected", n_checked);
        end else begin
          want = line_status_q.pop_front();
          if (got.level !== want.level || got.accepted !== want.accepted ||
              got.free !== want.free || got.busy !== want.busy ||
              got.latched !== want.latched) begin
            fault_cnt++;
            if (fault_cnt <= REPORT_MAX)
              $display("result %0d: exp lvl=%b acc=%b free=%b busy=%b latch=%b, got %b %b %b %b %b",
                       n_checked, want.level, want.accepted, want.free, want.busy, want.latched,
                       got.level, got.accepted, got.free, got.busy, got.latched);
          end
        end
      end
      if (!held_once && n_checked >= HOLD_OFF_AT) begin
        held_once = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (epoch_left == 0) begin
        mode = $urandom_range(0, 3);
        epoch_left = $urandom_range(20, 80);
      end else begin
        epoch_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= epoch_left[0];
        endcase
      end
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("no word moved for %0d cycles", STUCK_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Main sequence
  initial begin
    // want bits: level, accepted, free, busy, latched
    plan = '{
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ONE_HIGH, 20'd0, 1'b1, 5'b00100},
      '{ROW_CFG, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ONE_HIGH, 20'd2, 1'b0, 5'b00000},
      // bits above the register width are dropped
      '{ROW_CFG, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ONE_LOW, 20'h01001, 1'b0, 5'b00000},
      // zero count behaves as one tick
      '{ROW_CFG, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ZERO_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_CFG, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ZERO_LOW, 20'd1, 1'b0, 5'b00000},
      '{ROW_CFG, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_LATCH_GAP, 20'd0, 1'b0, 5'b00000},
      // index past the register list is ignored
      '{ROW_CFG, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_UNUSED, 20'hFFFFF, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_LOAD, 8'hFF, 8'h00, 8'hA5, 1'b0, 1, REG_ONE_HIGH, 20'd0, 1'b1, 5'b01000},
      // buffer full: load refused
      '{ROW_WORD, CMD_LOAD, 8'h12, 8'h34, 8'h56, 1'b1, 1, REG_ONE_HIGH, 20'd0, 1'b1, 5'b00000},
      // waiting pixel starts high on the next tick
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ONE_HIGH, 20'd0, 1'b1, 5'b10110},
      // second pixel follows the first without a gap, then underrun
      '{ROW_WORD, CMD_LOAD, 8'h00, 8'hFF, 8'h5A, 1'b0, 1, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 130, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_LOAD, 8'h80, 8'h01, 8'h00, 1'b1, 1, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 40, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      // queued behind a last pixel: waits out the latch gap
      '{ROW_WORD, CMD_LOAD, 8'h00, 8'h00, 8'h01, 1'b1, 1, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 70, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 80, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_LOAD, 8'h00, 8'h00, 8'h00, 1'b0, 1, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000},
      '{ROW_WORD, CMD_TICK, 8'h00, 8'h00, 8'h00, 1'b0, 60, REG_ONE_HIGH, 20'd0, 1'b0, 5'b00000}
    };

    // reset
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].val);
      else repeat (plan[i].reps)
        send_item(plan[i].cmd, {plan[i].g, plan[i].r, plan[i].b}, plan[i].last,
                  plan[i].typed, plan[i].want);
    end

    // short random timing, one pause to empty the pipeline
    set_timing(CFG_DATA_BITS'($urandom_range(1, 3)), CFG_DATA_BITS'($urandom_range(1, 3)),
               CFG_DATA_BITS'($urandom_range(1, 3)), CFG_DATA_BITS'($urandom_range(1, 3)),
               CFG_DATA_BITS'($urandom_range(2, 30)));
    run_random(170, 1'b1);

    // minimum counts, sender never idles
    sender_steady = 1'b1;
    set_timing(20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
    run_random(130, 1'b0);
    sender_steady = 1'b0;

    // maximum counts on one bits and maximum latch gap written, zero bits sent
    set_timing(20'hFFF, 20'hFFF, 20'd1, 20'd1, 20'hFFFFF);
    send_item(CMD_LOAD, 24'h000000, 1'b0, 1'b0, '0);
    flush_line();

    // random timing with zero counts possible
    set_timing(CFG_DATA_BITS'($urandom_range(0, 4)), CFG_DATA_BITS'($urandom_range(0, 4)),
               CFG_DATA_BITS'($urandom_range(0, 4)), CFG_DATA_BITS'($urandom_range(0, 4)),
               CFG_DATA_BITS'($urandom_range(0, 60)));
    run_random(170, 1'b0);

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (line_status_q.size() != 0) begin
      fault_cnt++;
      $display("%0d results never arrived", line_status_q.size());
    end

    $display("Covered %0d words: %0d ticks, %0d loads (%0d refused on a full buffer).",
             n_ticks + n_loads, n_ticks, n_loads, n_refused);
    $display("%0d pixels sent, %0d frames latched, %0d timing sets, %0d results checked.",
             n_pixels, n_frames, n_settings, n_checked);
    if (fault_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fault_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/alld_pkg.sv
design/alld_front.sv
design/alld_queue.sv
design/alld_back.sv
design/addressable_led_line_driver_unit.sv
tb/tb.sv
